// File: rtl/postfix_stack_evaluator_macros.svh
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// concurrent check, inactive while reset is asserted
`define PSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check whose consequent is evaluated in the cycle after the antecedent
`define PSE_ASSERT_NEXT(name, pre, post, msg) \
  `PSE_ASSERT(name, pre |=> post, msg)

`endif

// File: rtl/pse_pkg.sv
package pse_pkg;

  localparam int StackDepth = 16;
  localparam int StackAw    = $clog2(StackDepth);
  localparam int StackCw    = $clog2(StackDepth + 1);

  localparam int QueueDepth = 2;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  localparam int DivSteps = 32;
  localparam int DivCw    = $clog2(DivSteps + 1);

  localparam logic [1:0] ModePush   = 2'd0;
  localparam logic [1:0] ModeApply  = 2'd1;
  localparam logic [1:0] ModeFinish = 2'd2;
  localparam logic [1:0] ModeNone   = 2'd3;

  localparam logic [3:0] OpAdd = 4'd0;
  localparam logic [3:0] OpSub = 4'd1;
  localparam logic [3:0] OpMul = 4'd2;
  localparam logic [3:0] OpDiv = 4'd3;
  localparam logic [3:0] OpGt  = 4'd4;
  localparam logic [3:0] OpLt  = 4'd5;
  localparam logic [3:0] OpEq  = 4'd6;
  localparam logic [3:0] OpAnd = 4'd7;
  localparam logic [3:0] OpOr  = 4'd8;
  localparam logic [3:0] OpXor = 4'd9;
  localparam logic [3:0] OpNot = 4'd10;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StMissing  = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;
  localparam logic [1:0] StDivZero  = 2'd3;

  typedef enum logic [1:0] {
    KindPush,
    KindUnary,
    KindBinary,
    KindFinish
  } kind_e;

  typedef enum logic [1:0] {
    BsIdle,
    BsExec,
    BsDiv,
    BsWb
  } back_state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         opcode;
    logic signed [31:0] value;
  } pse_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } pse_out_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  opcode;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/pse_ram.sv
module pse_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pse_fifo.sv
module pse_fifo import pse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t               entry_q [QueueDepth];
  logic [QueueAw-1:0] wptr_q, wptr_d;
  logic [QueueAw-1:0] rptr_q, rptr_d;
  logic [QueueCw-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QueueCw'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == QueueAw'(QueueDepth - 1)) ? '0 : wptr_q + QueueAw'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QueueAw'(QueueDepth - 1)) ? '0 : rptr_q + QueueAw'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCw'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/pse_front.sv
module pse_front import pse_pkg::*; (
  input  logic    push_i,
  input  pse_in_t in_data_i,
  output logic    full_o,
  input  logic    fifo_full_i,
  output logic    fifo_push_o,
  output cmd_t    fifo_data_o
);

  logic keep;

  // items that change nothing never enter the queue
  always_comb begin
    keep               = 1'b0;
    fifo_data_o.kind   = KindPush;
    fifo_data_o.opcode = in_data_i.opcode;
    fifo_data_o.value  = in_data_i.value;
    unique case (in_data_i.mode)
      ModePush: begin
        keep = 1'b1;
      end
      ModeApply: begin
        keep             = (in_data_i.opcode <= OpNot);
        fifo_data_o.kind = (in_data_i.opcode == OpNot) ? KindUnary : KindBinary;
      end
      ModeFinish: begin
        keep             = 1'b1;
        fifo_data_o.kind = KindFinish;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o             = fifo_full_i;
  assign fifo_push_o        = push_i && !fifo_full_i && keep;

endmodule

// File: rtl/pse_div.sv
module pse_div import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0]    dvd_q, dvd_d;
  logic [31:0]    rem_q, rem_d;
  logic [31:0]    dsr_q, dsr_d;
  logic           neg_q, neg_d;
  logic [DivCw-1:0] cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [32:0]    rem_sh, diff;

  assign rem_sh = {rem_q, dvd_q[31]};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend[31] ? (32'd0 - req_i.dividend) : req_i.dividend;
      dsr_d = req_i.divisor[31] ? (32'd0 - req_i.divisor) : req_i.divisor;
      neg_d = req_i.dividend[31] ^ req_i.divisor[31];
      rem_d = '0;
      cnt_d = DivCw'(DivSteps);
    end else if (cnt_q != '0) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        dvd_d = {dvd_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        dvd_d = {dvd_q[30:0], 1'b0};
      end
      cnt_d  = cnt_q - DivCw'(1);
      done_d = (cnt_q == DivCw'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (32'd0 - dvd_q) : dvd_q;

endmodule

// File: rtl/pse_back.sv
module pse_back import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fifo_empty_i,
  input  cmd_t     fifo_data_i,
  output logic     fifo_pop_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  input  logic     pop_i,
  output pse_out_t out_data_o,
  output logic     empty_o
);

  back_state_e        state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [StackCw-1:0] cnt_q, cnt_d;
  logic [31:0]        tos_q, tos_d;
  logic [31:0]        last_q, last_d;
  logic [1:0]         err_q, err_d;
  logic               aborted_q, aborted_d;
  logic [31:0]        res_q, res_d;
  pse_out_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               we;
  logic [StackAw-1:0] waddr;
  logic [31:0]        wdata;
  logic [StackAw-1:0] raddr;
  logic [31:0]        x, y;
  logic [StackCw-1:0] cnt_m1, cnt_m2;
  logic               bin_ok;
  logic               commit;
  logic [31:0]        commit_val;
  logic [31:0]        alu_r, not_r, mul_lo;

  assign cnt_m1 = cnt_q - StackCw'(1);
  assign cnt_m2 = cnt_q - StackCw'(2);
  assign raddr  = cnt_m2[StackAw-1:0];
  assign y      = tos_q;
  assign bin_ok = (cmd_q.kind == KindBinary) && !aborted_q && (cnt_q >= StackCw'(2));

  pse_ram #(
    .Width (32),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (x)
  );

  assign mul_lo = x * y;
  assign not_r  = {31'd0, (y == '0) || y[31]};

  always_comb begin
    case (cmd_q.opcode)
      OpAdd:   alu_r = x + y;
      OpSub:   alu_r = x - y;
      OpGt:    alu_r = {31'd0, $signed(x) > $signed(y)};
      OpLt:    alu_r = {31'd0, $signed(x) < $signed(y)};
      OpEq:    alu_r = {31'd0, x == y};
      OpAnd:   alu_r = {31'd0, (x != '0) && (y != '0)};
      OpOr:    alu_r = {31'd0, (x != '0) || (y != '0)};
      OpXor:   alu_r = {31'd0, (x != '0) != (y != '0)};
      default: alu_r = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BsIdle: begin
        if (!fifo_empty_i) begin
          state_d = BsExec;
        end
      end
      BsExec: begin
        if (cmd_q.kind == KindFinish && out_valid_q) begin
          state_d = BsExec;
        end else if (bin_ok && cmd_q.opcode == OpMul) begin
          state_d = BsWb;
        end else if (bin_ok && cmd_q.opcode == OpDiv && y != '0) begin
          state_d = BsDiv;
        end else begin
          state_d = BsIdle;
        end
      end
      BsDiv: begin
        if (div_rsp_i.done) begin
          state_d = BsWb;
        end
      end
      BsWb: begin
        state_d = BsIdle;
      end
      default: begin
        state_d = BsIdle;
      end
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    tos_d       = tos_q;
    last_d      = last_q;
    err_d       = err_q;
    aborted_d   = aborted_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    fifo_pop_o  = 1'b0;
    we          = 1'b0;
    waddr       = cnt_q[StackAw-1:0];
    wdata       = cmd_q.value;
    commit      = 1'b0;
    commit_val  = res_q;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = x;
    div_req_o.divisor  = y;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      BsIdle: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          cmd_d      = fifo_data_i;
        end
      end
      BsExec: begin
        unique case (cmd_q.kind)
          KindPush: begin
            if (!aborted_q) begin
              if (cnt_q == StackCw'(StackDepth)) begin
                err_d     = StOverflow;
                aborted_d = 1'b1;
              end else begin
                we    = 1'b1;
                tos_d = cmd_q.value;
                cnt_d = cnt_q + StackCw'(1);
              end
            end
          end
          KindUnary: begin
            if (!aborted_q) begin
              if (cnt_q == '0) begin
                err_d     = StMissing;
                aborted_d = 1'b1;
              end else begin
                commit     = 1'b1;
                commit_val = not_r;
              end
            end
          end
          KindBinary: begin
            if (!aborted_q) begin
              if (!bin_ok) begin
                err_d     = StMissing;
                aborted_d = 1'b1;
              end else if (cmd_q.opcode == OpMul) begin
                res_d = mul_lo;
              end else if (cmd_q.opcode == OpDiv) begin
                if (y == '0) begin
                  err_d     = StDivZero;
                  aborted_d = 1'b1;
                end else begin
                  div_req_o.start = 1'b1;
                end
              end else begin
                commit     = 1'b1;
                commit_val = alu_r;
              end
            end
          end
          KindFinish: begin
            if (!out_valid_q) begin
              out_valid_d = 1'b1;
              if (err_q != StOk) begin
                out_d.result = last_q;
                out_d.status = err_q;
              end else if (cnt_q == '0) begin
                out_d.result = last_q;
                out_d.status = StMissing;
              end else begin
                out_d.result = tos_q;
                out_d.status = StOk;
              end
              cnt_d     = '0;
              last_d    = '0;
              err_d     = StOk;
              aborted_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      BsDiv: begin
        if (div_rsp_i.done) begin
          res_d = div_rsp_i.quotient;
        end
      end
      BsWb: begin
        commit = 1'b1;
      end
      default: begin
      end
    endcase

    // operator result replaces its operands on top of the stack
    if (commit) begin
      we     = 1'b1;
      wdata  = commit_val;
      tos_d  = commit_val;
      last_d = commit_val;
      if (cmd_q.kind == KindUnary) begin
        waddr = cnt_m1[StackAw-1:0];
      end else begin
        waddr = cnt_m2[StackAw-1:0];
        cnt_d = cnt_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BsIdle;
      cnt_q       <= '0;
      last_q      <= '0;
      err_q       <= StOk;
      aborted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      err_q       <= err_d;
      aborted_q   <= aborted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    tos_q <= tos_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_data_o = out_q;
  assign empty_o    = !out_valid_q;

endmodule

// File: rtl/postfix_stack_evaluator.sv
// a finish result passes the queue, command register and result register, waiting while
// an earlier result is held; commands run one at a time with one stack read port, multiply
// adding a writeback state and divide waiting on the one-bit-per-cycle divider
// a 2-entry queue decouples acceptance from execution; the result register holds one result
// reset (async, active low) empties the queue, stack count, error state and result register;
// stack contents stay undefined and need no clearing pass
module postfix_stack_evaluator import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pse_in_t  in_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output pse_out_t out_data_o,
  output logic     empty_o
);

  logic     fifo_push, fifo_full, fifo_pop, fifo_empty;
  cmd_t     fifo_wdata, fifo_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pse_front u_front (
    .push_i      (push_i),
    .in_data_i   (in_data_i),
    .full_o      (full_o),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .fifo_data_o (fifo_wdata)
  );

  pse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (fifo_rdata),
    .empty_o (fifo_empty)
  );

  pse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_rdata),
    .fifo_pop_o   (fifo_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .pop_i        (pop_i),
    .out_data_o   (out_data_o),
    .empty_o      (empty_o)
  );

endmodule

// File: rtl/pse_checker.sv
`include "postfix_stack_evaluator_macros.svh"

module pse_checker import pse_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push_i,
  input pse_in_t  in_data_i,
  input logic     full_o,
  input logic     pop_i,
  input pse_out_t out_data_o,
  input logic     empty_o
);

  `PSE_ASSERT_NEXT(a_out_hold, !empty_o && !pop_i, !empty_o && $stable(out_data_o), "result changed while waiting")
  `PSE_ASSERT_NEXT(a_pop_drains, !empty_o && pop_i, empty_o, "single result slot not drained by pop")
  `PSE_ASSERT(a_full_needs_push, $rose(full_o) |-> $past(push_i), "queue filled without a push")
  `PSE_ASSERT_NEXT(a_no_mode_ignored, push_i && !full_o && in_data_i.mode == ModeNone, !$rose(full_o), "ignored transaction was queued")

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);
